// ===== src/sample_metadata_tlv_parser_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the sampled-packet metadata parser
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef SAMPLE_METADATA_TLV_PARSER_ASSERT_SVH
`define SAMPLE_METADATA_TLV_PARSER_ASSERT_SVH
`ifndef SYNTHESIS
`define SMTLV_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("smtlv: same-cycle check failed");
`define SMTLV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("smtlv: next-cycle check failed");
`else
`define SMTLV_ASSERT_IMPLY(label, ante, cons)
`define SMTLV_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== src/smtlv_pkg.sv =====
// ---------------------------------------------------------------------------
// smtlv_pkg
// Types and constants shared by the sampled-packet metadata parser.
// ---------------------------------------------------------------------------
package smtlv_pkg;

  localparam int MAX_MSG_BYTES = 16384;
  localparam int MAX_WORDS     = (MAX_MSG_BYTES + 3) / 4;
  localparam int WIDX_W        = $clog2(MAX_WORDS + 1);
  localparam int MSG_W         = WIDX_W + 2;
  localparam int HDR_W         = 15;
  localparam int QMAG_W        = 30;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [31:0] SIGNATURE     = 32'hDEADBEEF;
  localparam logic [31:0] ETH_HDR_BYTES = 32'd14;
  localparam logic [31:0] FCS_BYTES     = 32'd4;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_SIG   = 2'd1,
    ST_META_ERR  = 2'd2,
    ST_TOO_SMALL = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_TAG_LO = 3'd0,
    PH_TAG_HI = 3'd1,
    PH_LEN_LO = 3'd2,
    PH_LEN_HI = 3'd3,
    PH_VAL_LO = 3'd4,
    PH_VAL_HI = 3'd5,
    PH_DONE   = 3'd6
  } phase_t;

  typedef logic [3:0][31:0] field_arr_t;

  typedef struct packed {
    logic [31:0] word;
    logic        last;
    logic [2:0]  last_bytes;
  } in_t;

  typedef struct packed {
    status_t            status;
    logic [31:0]        in_port;
    logic [31:0]        out_port;
    logic [31:0]        seq_no;
    logic [31:0]        frame_len;
    logic [31:0]        dropped;
    logic [31:0]        total_dropped;
    logic [HDR_W-1:0]   header_len;
    logic signed [31:0] capture_len;
    logic signed [31:0] pdu_len;
  } out_t;

  // end-of-message record handed from the parser to the result pipeline
  typedef struct packed {
    logic              sig_bad;
    logic              meta_error;
    phase_t            phase;
    logic [WIDX_W-1:0] cursor;
    logic [31:0]       meta_bytes;
    logic [MSG_W-1:0]  msg_bytes;
    field_arr_t        fields;
  } msg_rec_t;

endpackage

// ===== src/smtlv_front.sv =====
// ---------------------------------------------------------------------------
// smtlv_front
// Word-by-word message parser: signature, metadata length and TLV walk.
// ---------------------------------------------------------------------------
module smtlv_front import smtlv_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_t      in_data,
  output logic     rec_valid,
  input  logic     rec_ready,
  output msg_rec_t rec_data
);

  logic [WIDX_W-1:0] word_index_r, word_index_nxt;
  logic [31:0]       meta_bytes_r, meta_bytes_nxt;
  logic [WIDX_W-1:0] cursor_r, cursor_nxt;
  phase_t            phase_r, phase_nxt;
  logic              tag_small_r, tag_small_nxt;
  logic [1:0]        tag_idx_r, tag_idx_nxt;
  logic              len4_r, len4_nxt;
  logic              len8_r, len8_nxt;
  logic              sig_bad_r, sig_bad_nxt;
  logic              meta_error_r, meta_error_nxt;
  field_arr_t        fields_r, fields_nxt;

  logic              fire;
  logic              accepted;
  logic [QMAG_W-1:0] cur_ext;
  logic [QMAG_W-1:0] cur4;
  logic              loop_end;
  logic              cursor_ne;
  logic [2:0]        lb_eff;
  logic [MSG_W-1:0]  msg_raw;
  logic [MSG_W-1:0]  msg_bytes;

  assign in_ready  = rec_ready;
  assign rec_valid = in_valid && in_data.last;

  always_comb begin
    word_index_nxt = word_index_r;
    meta_bytes_nxt = meta_bytes_r;
    cursor_nxt     = cursor_r;
    phase_nxt      = phase_r;
    tag_small_nxt  = tag_small_r;
    tag_idx_nxt    = tag_idx_r;
    len4_nxt       = len4_r;
    len8_nxt       = len8_r;
    sig_bad_nxt    = sig_bad_r;
    meta_error_nxt = meta_error_r;
    fields_nxt     = fields_r;

    fire     = in_valid && in_ready;
    accepted = word_index_r < WIDX_W'(MAX_WORDS);

    // quads = floor(signed meta_bytes / 4); negative when bit 31 is set
    cur_ext   = QMAG_W'(cursor_r);
    cur4      = cur_ext + QMAG_W'(4);
    loop_end  = meta_bytes_r[31] || (cur4 > meta_bytes_r[31:2]);
    cursor_ne = meta_bytes_r[31] || (cur_ext != meta_bytes_r[31:2]);

    if (fire && accepted) begin
      word_index_nxt = word_index_r + 1'b1;
      if (word_index_r == '0) begin
        sig_bad_nxt = in_data.word != SIGNATURE;
      end else if (word_index_r == WIDX_W'(1)) begin
        meta_bytes_nxt = in_data.word;
      end else if (phase_r != PH_DONE) begin
        cursor_nxt = cursor_r + 1'b1;
        case (phase_r)
          PH_TAG_LO: begin
            if (loop_end) begin
              phase_nxt      = PH_DONE;
              meta_error_nxt = cursor_ne;
              cursor_nxt     = cursor_r;
            end else begin
              tag_small_nxt = in_data.word < 32'd4;
              tag_idx_nxt   = in_data.word[1:0];
              phase_nxt     = PH_TAG_HI;
            end
          end
          PH_TAG_HI: begin
            tag_small_nxt = tag_small_r && (in_data.word == '0);
            phase_nxt     = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            len4_nxt  = in_data.word == 32'd4;
            len8_nxt  = in_data.word == 32'd8;
            phase_nxt = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            if ((in_data.word == '0) && (len4_r || len8_r)) begin
              phase_nxt = PH_VAL_LO;
            end else begin
              if (tag_small_r) begin
                fields_nxt[tag_idx_r] = '0;
              end
              phase_nxt = PH_TAG_LO;
            end
          end
          PH_VAL_LO: begin
            if (tag_small_r) begin
              fields_nxt[tag_idx_r] = in_data.word;
            end
            phase_nxt = len8_r ? PH_VAL_HI : PH_TAG_LO;
          end
          PH_VAL_HI: begin
            phase_nxt = PH_TAG_LO;
          end
          default: begin
            cursor_nxt = cursor_r;
          end
        endcase
      end
    end

    if (in_data.last_bytes inside {[3'd1:3'd4]}) begin
      lb_eff = in_data.last_bytes;
    end else begin
      lb_eff = 3'd4;
    end
    msg_raw = {word_index_r, 2'b00} + MSG_W'(lb_eff);
    if (!accepted || (msg_raw > MSG_W'(MAX_MSG_BYTES))) begin
      msg_bytes = MSG_W'(MAX_MSG_BYTES);
    end else begin
      msg_bytes = msg_raw;
    end

    rec_data.sig_bad    = sig_bad_nxt;
    rec_data.meta_error = meta_error_nxt;
    rec_data.phase      = phase_nxt;
    rec_data.cursor     = cursor_nxt;
    rec_data.meta_bytes = meta_bytes_nxt;
    rec_data.msg_bytes  = msg_bytes;
    rec_data.fields     = fields_nxt;

    if (fire && in_data.last) begin
      word_index_nxt = '0;
      meta_bytes_nxt = '0;
      cursor_nxt     = WIDX_W'(2);
      phase_nxt      = PH_TAG_LO;
      tag_small_nxt  = 1'b0;
      tag_idx_nxt    = '0;
      len4_nxt       = 1'b0;
      len8_nxt       = 1'b0;
      sig_bad_nxt    = 1'b0;
      meta_error_nxt = 1'b0;
      fields_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_index_r <= '0;
      meta_bytes_r <= '0;
      cursor_r     <= WIDX_W'(2);
      phase_r      <= PH_TAG_LO;
      tag_small_r  <= 1'b0;
      tag_idx_r    <= '0;
      len4_r       <= 1'b0;
      len8_r       <= 1'b0;
      sig_bad_r    <= 1'b0;
      meta_error_r <= 1'b0;
      fields_r     <= '0;
    end else begin
      word_index_r <= word_index_nxt;
      meta_bytes_r <= meta_bytes_nxt;
      cursor_r     <= cursor_nxt;
      phase_r      <= phase_nxt;
      tag_small_r  <= tag_small_nxt;
      tag_idx_r    <= tag_idx_nxt;
      len4_r       <= len4_nxt;
      len8_r       <= len8_nxt;
      sig_bad_r    <= sig_bad_nxt;
      meta_error_r <= meta_error_nxt;
      fields_r     <= fields_nxt;
    end
  end

endmodule

// ===== src/smtlv_queue.sv =====
// ---------------------------------------------------------------------------
// smtlv_queue
// Short FIFO of end-of-message records between parser and result pipeline.
// ---------------------------------------------------------------------------
module smtlv_queue import smtlv_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  msg_rec_t push_data,
  output logic     pop_valid,
  input  logic     pop_ready,
  output msg_rec_t pop_data
);

  msg_rec_t          entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push;
  logic              pop;

  always_comb begin
    push_ready = count_r != QCNT_W'(QUEUE_DEPTH);
    pop_valid  = count_r != '0;
    pop_data   = entry_r[rd_ptr_r];
    push       = push_valid && push_ready;
    pop        = pop_valid && pop_ready;

    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== src/smtlv_back.sv =====
// ---------------------------------------------------------------------------
// smtlv_back
// Two-stage result pipeline: status and lengths, then drop accounting.
// ---------------------------------------------------------------------------
module smtlv_back import smtlv_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     rec_valid,
  output logic     rec_ready,
  input  msg_rec_t rec_data,
  output logic     out_valid,
  input  logic     out_ready,
  output out_t     out_data
);

  // stage A
  logic              a_valid_r, a_valid_nxt;
  status_t           a_status_r, a_status_nxt;
  logic [31:0]       a_hl_r, a_hl_nxt;
  logic [31:0]       a_hlm14_r, a_hlm14_nxt;
  logic [31:0]       a_pdu_r, a_pdu_nxt;
  field_arr_t        a_fields_r, a_fields_nxt;

  // output stage
  logic              out_valid_r, out_valid_nxt;
  out_t              out_r, out_nxt;
  logic [31:0]       last_seq_r, last_seq_nxt;
  logic [31:0]       drop_total_r, drop_total_nxt;

  logic              b_ready;
  logic              a_load;
  logic              b_load;
  logic [QMAG_W-1:0] cur_ext;
  logic [QMAG_W-1:0] cur4;
  logic              loop_more;
  logic              cursor_ne;
  logic              err;
  logic signed [33:0] hl_full;
  logic [31:0]       chop;
  logic              chop_small;
  logic [31:0]       dropped;
  logic [31:0]       total;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    b_ready   = !out_valid_r || out_ready;
    rec_ready = !a_valid_r || b_ready;
    a_load    = rec_valid && rec_ready;
    b_load    = a_valid_r && b_ready;

    // stage A: metadata consumption check, header length, status
    cur_ext   = QMAG_W'(rec_data.cursor);
    cur4      = cur_ext + QMAG_W'(4);
    loop_more = !rec_data.meta_bytes[31] && (cur4 <= rec_data.meta_bytes[31:2]);
    cursor_ne = rec_data.meta_bytes[31] || (cur_ext != rec_data.meta_bytes[31:2]);
    case (rec_data.phase)
      PH_DONE:   err = rec_data.meta_error;
      PH_TAG_LO: err = loop_more || cursor_ne;
      default:   err = 1'b1;
    endcase

    hl_full = $signed(34'(rec_data.msg_bytes)) - $signed(34'($signed(rec_data.meta_bytes)));

    if (rec_data.sig_bad) begin
      a_status_nxt = ST_BAD_SIG;
    end else if (err) begin
      a_status_nxt = ST_META_ERR;
    end else if (hl_full < 34'sd14) begin
      a_status_nxt = ST_TOO_SMALL;
    end else begin
      a_status_nxt = ST_OK;
    end
    a_hl_nxt     = hl_full[31:0];
    a_hlm14_nxt  = hl_full[31:0] - ETH_HDR_BYTES;
    a_pdu_nxt    = rec_data.fields[3] - (ETH_HDR_BYTES + FCS_BYTES);
    a_fields_nxt = rec_data.fields;

    a_valid_nxt = a_valid_r;
    if (a_load) begin
      a_valid_nxt = 1'b1;
    end else if (b_load) begin
      a_valid_nxt = 1'b0;
    end

    // stage B: FCS trim and sequence gap
    // with fewer than 4 chopped bytes, header - 14 - fcs reduces to frame - 18
    chop       = a_fields_r[3] - a_hl_r;
    chop_small = $signed(chop) < 32'sd4;
    dropped    = (last_seq_r == '0) ? '0 : a_fields_r[2] + ~last_seq_r;
    total      = drop_total_r + dropped;

    out_nxt        = '0;
    out_nxt.status = a_status_r;
    last_seq_nxt   = last_seq_r;
    drop_total_nxt = drop_total_r;
    if (a_status_r == ST_OK) begin
      out_nxt.in_port       = a_fields_r[0];
      out_nxt.out_port      = a_fields_r[1];
      out_nxt.seq_no        = a_fields_r[2];
      out_nxt.frame_len     = a_fields_r[3];
      out_nxt.dropped       = dropped;
      out_nxt.total_dropped = total;
      out_nxt.header_len    = a_hl_r[HDR_W-1:0];
      out_nxt.capture_len   = chop_small ? a_pdu_r : a_hlm14_r;
      out_nxt.pdu_len       = a_pdu_r;
      if (b_load) begin
        last_seq_nxt   = a_fields_r[2];
        drop_total_nxt = total;
      end
    end

    out_valid_nxt = out_valid_r;
    if (b_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      last_seq_r   <= '0;
      drop_total_r <= '0;
    end else begin
      a_valid_r    <= a_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      last_seq_r   <= last_seq_nxt;
      drop_total_r <= drop_total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_status_r <= a_status_nxt;
      a_hl_r     <= a_hl_nxt;
      a_hlm14_r  <= a_hlm14_nxt;
      a_pdu_r    <= a_pdu_nxt;
      a_fields_r <= a_fields_nxt;
    end
    if (b_load) begin
      out_r <= out_nxt;
    end
  end

endmodule

// ===== src/sample_metadata_tlv_parser.sv =====
// ---------------------------------------------------------------------------
// sample_metadata_tlv_parser
// Sampled-packet message metadata parser, top level.
// ---------------------------------------------------------------------------
// The block takes one 32-bit message word per cycle with no bubbles while the
// record queue has room; each word updates the registered TLV parse state.
// Only the final word of a message yields a transaction on the output:
// out_valid rises once its record has passed from the queue through the
// first pipeline stage into the output register. A two-entry queue decouples
// the parser from the two-stage result pipeline (status and lengths, then
// drop accounting). While a result waits on out_ready the parser keeps
// taking words until three more end-of-message records are held behind it
// (one in the first pipeline stage, two in the queue); then in_ready drops
// for every word. Words beyond the maximum message size are dropped silently.
`include "sample_metadata_tlv_parser_assert.svh"

module sample_metadata_tlv_parser import smtlv_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic     push_valid;
  logic     push_ready;
  msg_rec_t push_data;
  logic     pop_valid;
  logic     pop_ready;
  msg_rec_t pop_data;

  smtlv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .rec_valid (push_valid),
    .rec_ready (push_ready),
    .rec_data  (push_data)
  );

  smtlv_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  smtlv_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_valid (pop_valid),
    .rec_ready (pop_ready),
    .rec_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `SMTLV_ASSERT_IMPLY(a_err_zero_fields, out_valid && (out_data.status != ST_OK), (out_data.seq_no == '0) && (out_data.dropped == '0) && (out_data.total_dropped == '0) && (out_data.frame_len == '0))
  `SMTLV_ASSERT_IMPLY(a_ok_hdr_min, out_valid && (out_data.status == ST_OK), out_data.header_len >= 15'd14)
  `SMTLV_ASSERT_IMPLY(a_ok_capture, out_valid && (out_data.status == ST_OK), (out_data.capture_len == out_data.pdu_len) || (out_data.capture_len == $signed({17'd0, out_data.header_len}) - 32'sd14))
  `SMTLV_ASSERT_NEXT(a_total_chain, out_valid && out_ready && (out_data.status == ST_OK), !out_valid || (out_data.status != ST_OK) || (out_data.total_dropped == $past(out_data.total_dropped) + out_data.dropped))

endmodule

// ===== tb/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Testbench for the sampled-packet metadata TLV parser. Messages are fed word
// by word over the valid/ready input, and a cycle-free model of the parser
// runs alongside to predict each end-of-message summary. The summaries are
// compared field by field as they leave the block. Short directed messages
// come first, then randomized traffic. The random traffic is mostly
// well-formed TLV metadata with corrupted, truncated and noise messages mixed
// in, under several sender/receiver idling mixes.
// ---------------------------------------------------------------------------
module tb_top;
  import smtlv_pkg::*;

  localparam longint MIN_HDR = 14;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  sample_metadata_tlv_parser DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // parser model state
  int          words_taken;
  logic [31:0] meta_len;
  longint      tlv_pos;
  phase_t      tlv_state;
  logic [63:0] tlv_tag;
  logic [63:0] tlv_len;
  logic        sig_mismatch;
  logic        meta_fault;
  logic [31:0] tag_vals [4];
  logic [31:0] prev_seq;
  logic [31:0] drop_sum;

  out_t        pending_summaries[$];
  int          mismatches = 0;
  int          words_sent = 0;
  int          msgs_sent = 0;
  int          status_seen [4] = '{0, 0, 0, 0};
  int          idle_pct = 0;
  int          stall_pct = 0;
  logic [31:0] seq_gen = 32'd100;

  function automatic void clear_message_state();
    words_taken  = 0;
    meta_len     = '0;
    tlv_pos      = 2;
    tlv_state    = PH_TAG_LO;
    tlv_tag      = '0;
    tlv_len      = '0;
    sig_mismatch = 1'b0;
    meta_fault   = 1'b0;
    foreach (tag_vals[i]) tag_vals[i] = '0;
  endfunction

  // metadata length in whole words, rounded toward minus infinity
  function automatic longint meta_words();
    return longint'($signed(meta_len) >>> 2);
  endfunction

  function automatic void store_tag(logic [31:0] val);
    if (tlv_tag < 64'd4) tag_vals[tlv_tag[1:0]] = val;
  endfunction

  function automatic void advance_tlv(logic [31:0] w);
    case (tlv_state)
      PH_TAG_LO: begin
        if (tlv_pos + 4 > meta_words()) begin
          tlv_state  = PH_DONE;
          meta_fault = (tlv_pos != meta_words());
          return;
        end
        tlv_tag   = {32'd0, w};
        tlv_state = PH_TAG_HI;
      end
      PH_TAG_HI: begin
        tlv_tag[63:32] = w;
        tlv_state      = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        tlv_len   = {32'd0, w};
        tlv_state = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        tlv_len[63:32] = w;
        if (tlv_len == 64'd4 || tlv_len == 64'd8) begin
          tlv_state = PH_VAL_LO;
        end else begin
          store_tag(32'd0);
          tlv_state = PH_TAG_LO;
        end
      end
      PH_VAL_LO: begin
        store_tag(w);
        tlv_state = (tlv_len == 64'd8) ? PH_VAL_HI : PH_TAG_LO;
      end
      PH_VAL_HI: begin
        tlv_state = PH_TAG_LO;
      end
      default: return;
    endcase
    tlv_pos++;
  endfunction

  function automatic void take_word(in_t item);
    logic        fits;
    logic        bad_meta;
    int          pos;
    int          lb;
    longint      msg_bytes;
    longint      hdr;
    longint      quads;
    longint      chopped;
    longint      fcs;
    logic [31:0] chop_u;
    logic [31:0] gap;
    out_t        res;
    fits = words_taken < MAX_WORDS;
    pos  = words_taken;
    if (fits) begin
      if (pos == 0) sig_mismatch = (item.word != SIGNATURE);
      else if (pos == 1) meta_len = item.word;
      else if (tlv_state != PH_DONE) advance_tlv(item.word);
      words_taken++;
    end
    if (!item.last) return;

    lb = item.last_bytes;
    if (lb == 0 || lb > 4) lb = 4;
    msg_bytes = fits ? longint'(pos) * 4 + lb : longint'(MAX_MSG_BYTES);
    if (msg_bytes > MAX_MSG_BYTES) msg_bytes = MAX_MSG_BYTES;

    quads = meta_words();
    if (tlv_state == PH_DONE) bad_meta = meta_fault;
    else if (tlv_state == PH_TAG_LO) bad_meta = (tlv_pos + 4 <= quads) || (tlv_pos != quads);
    else bad_meta = 1'b1;
    hdr = msg_bytes - longint'($signed(meta_len));

    res = '0;
    if (sig_mismatch) begin
      res.status = ST_BAD_SIG;
    end else if (bad_meta) begin
      res.status = ST_META_ERR;
    end else if (hdr < MIN_HDR) begin
      res.status = ST_TOO_SMALL;
    end else begin
      res.status = ST_OK;
      chop_u  = tag_vals[3] - hdr[31:0];
      chopped = longint'($signed(chop_u));
      fcs     = (chopped < 4) ? 4 - chopped : 0;
      gap     = '0;
      if (prev_seq != 32'd0) begin
        gap      = tag_vals[2] - prev_seq - 32'd1;
        drop_sum = drop_sum + gap;
      end
      prev_seq = tag_vals[2];
      res.in_port       = tag_vals[0];
      res.out_port      = tag_vals[1];
      res.seq_no        = tag_vals[2];
      res.frame_len     = tag_vals[3];
      res.dropped       = gap;
      res.total_dropped = drop_sum;
      res.header_len    = hdr[HDR_W-1:0];
      res.capture_len   = 32'(hdr - MIN_HDR - fcs);
      res.pdu_len       = tag_vals[3] - 32'd18;
    end
    status_seen[res.status]++;
    pending_summaries.push_back(res);
    clear_message_state();
  endfunction

  function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, actual %h", $time, fname, want, got);
      mismatches++;
    end
  endfunction

  task automatic compare_summary(out_t want, out_t got);
    check_field("status", want.status, got.status);
    check_field("in_port", want.in_port, got.in_port);
    check_field("out_port", want.out_port, got.out_port);
    check_field("seq_no", want.seq_no, got.seq_no);
    check_field("frame_len", want.frame_len, got.frame_len);
    check_field("dropped", want.dropped, got.dropped);
    check_field("total_dropped", want.total_dropped, got.total_dropped);
    check_field("header_len", want.header_len, got.header_len);
    check_field("capture_len", want.capture_len, got.capture_len);
    check_field("pdu_len", want.pdu_len, got.pdu_len);
  endtask

  // sampled mid-cycle; a transaction here completes at the next rising edge
  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_summaries.size() == 0) begin
        $display("%0t: result with none pending, actual %p", $time, out_data);
        mismatches++;
      end else begin
        compare_summary(pending_summaries.pop_front(), out_data);
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic send_word(logic [31:0] w, logic lst, logic [2:0] lb);
    in_t item;
    item = '{word: w, last: lst, last_bytes: lb};
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    take_word(item);
    words_sent++;
  endtask

  task automatic send_message(logic [31:0] words[$], logic [2:0] lb);
    foreach (words[i])
      send_word(words[i], i == words.size() - 1,
                (i == words.size() - 1) ? lb : 3'($urandom));
    msgs_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_summaries.size() != 0) @(posedge clk);
  endtask

  task automatic build_message(ref logic [31:0] words[$], output logic [2:0] lb);
    int          kind;
    int          r;
    int          n_tlv;
    int          hw;
    int          lb_eff;
    int          hdr;
    int          cut;
    logic [31:0] tag_lo;
    logic [31:0] tag_hi;
    logic [31:0] len_lo;
    logic [31:0] len_hi;
    logic [31:0] val;
    logic [31:0] flen;
    logic [31:0] body[$];
    kind   = $urandom_range(0, 99);
    hw     = (kind >= 89 && kind < 94) ? $urandom_range(0, 4) : $urandom_range(4, 10);
    lb     = ($urandom_range(0, 9) < 7) ? 3'($urandom_range(1, 4)) : 3'($urandom_range(0, 7));
    lb_eff = (lb == 0 || lb > 4) ? 4 : int'(lb);
    hdr    = hw * 4 - 4 + lb_eff;
    flen   = ($urandom_range(0, 9) < 8) ? 32'(hdr + $urandom_range(0, 12) - 6) : $urandom;
    case ($urandom_range(0, 19))
      0: seq_gen = 32'd0;
      1: seq_gen = $urandom;
      default: seq_gen = seq_gen + $urandom_range(1, 3);
    endcase

    n_tlv = $urandom_range(0, 4);
    for (int t = 0; t < n_tlv; t++) begin
      r      = $urandom_range(0, 19);
      tag_lo = (r < 17) ? $urandom_range(0, 3) : $urandom;
      tag_hi = (r >= 15) ? $urandom : 32'd0;
      r      = $urandom_range(0, 19);
      len_hi = 32'd0;
      if (r < 9) len_lo = 32'd4;
      else if (r < 16) len_lo = 32'd8;
      else if (r == 16) begin
        len_lo = 32'd4;
        len_hi = 32'd1 << $urandom_range(0, 31);
      end else if (r == 17) begin
        len_lo = 32'd8;
        len_hi = 32'd1 << $urandom_range(0, 31);
      end else if (r == 18) len_lo = $urandom_range(0, 12);
      else len_lo = $urandom;
      if (tag_lo == 32'd2) val = seq_gen;
      else if (tag_lo == 32'd3) val = flen;
      else val = $urandom;
      body.push_back(tag_lo);
      body.push_back(tag_hi);
      body.push_back(len_lo);
      body.push_back(len_hi);
      if ({len_hi, len_lo} == 64'd4) body.push_back(val);
      if ({len_hi, len_lo} == 64'd8) begin
        body.push_back(val);
        body.push_back($urandom);
      end
    end

    words.delete();
    words.push_back(SIGNATURE);
    words.push_back(32'((2 + body.size()) * 4));
    foreach (body[i]) words.push_back(body[i]);
    repeat (hw) words.push_back($urandom);

    if (kind >= 70 && kind < 78) begin
      words[1] = ($urandom_range(0, 3) == 0) ? $urandom : words[1] + $urandom_range(1, 9) - 5;
    end else if (kind >= 78 && kind < 84) begin
      cut   = $urandom_range(1, 1 + body.size());
      words = words[0:cut];
    end else if (kind >= 84 && kind < 89) begin
      words[0] = words[0] ^ (32'd1 << $urandom_range(0, 31));
    end else if (kind >= 94) begin
      words.delete();
      repeat ($urandom_range(1, 10)) words.push_back($urandom);
      if ($urandom_range(0, 1)) words[0] = SIGNATURE;
    end
  endtask

  task automatic test_bad_signature();
    logic [31:0] msg[$];
    msg = {32'hFFFF_FFFF, 32'h0000_0000};
    send_message(msg, 3'd7);
  endtask

  task automatic test_missing_metadata();
    logic [31:0] msg[$];
    msg = {SIGNATURE};
    send_message(msg, 3'd4);
  endtask

  task automatic test_min_header();
    logic [31:0] msg[$];
    msg = {SIGNATURE, 32'd8, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF};
    send_message(msg, 3'd2);
  endtask

  task automatic test_header_too_small();
    logic [31:0] msg[$];
    msg = {SIGNATURE, 32'd8, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0};
    send_message(msg, 3'd1);
  endtask

  task automatic test_negative_meta_len();
    logic [31:0] msg[$];
    msg = {SIGNATURE, 32'h8000_0000, 32'd0};
    send_message(msg, 3'd0);
  endtask

  task automatic test_seq_tlv();
    logic [31:0] msg[$];
    msg = {SIGNATURE, 32'd32, 32'd2, 32'd0, 32'd8, 32'd0, 32'd1, 32'hFFFF_FFFF,
           32'd0, 32'd0, 32'd0, 32'd0};
    send_message(msg, 3'd4);
  endtask

  task automatic test_random_traffic(int n_words, int idle, int stall);
    logic [31:0] words[$];
    logic [2:0]  lb;
    int          target;
    drain_results();
    idle_pct  = idle;
    stall_pct = stall;
    target    = words_sent + n_words;
    while (words_sent < target) begin
      build_message(words, lb);
      send_message(words, lb);
      if ($urandom_range(0, 29) == 0) drain_results();
    end
  endtask

  initial begin
    clear_message_state();
    prev_seq = '0;
    drop_sum = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_bad_signature();
    test_missing_metadata();
    test_min_header();
    test_header_too_small();
    test_negative_meta_len();
    test_seq_tlv();
    test_random_traffic(375, 0, 0);
    test_random_traffic(375, 50, 0);
    test_random_traffic(375, 0, 50);
    test_random_traffic(375, 26, 26);

    drain_results();
    repeat (10) @(posedge clk);
    $display("Sent %0d words in %0d messages under four idle/stall mixes",
             words_sent, msgs_sent);
    $display("Outcomes: ok %0d, bad signature %0d, metadata error %0d, too small %0d",
             status_seen[ST_OK], status_seen[ST_BAD_SIG], status_seen[ST_META_ERR],
             status_seen[ST_TOO_SMALL]);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t: timeout, %0d results still pending", $time, pending_summaries.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
